### rtl/core/bpc_pkg.sv
package bpc_pkg;

  localparam int RAW_W      = 24;
  localparam int PRESSURE_W = 23;
  localparam int TEMP_W     = 16;
  localparam int CALIB_W    = 168;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_HIGH_W = 40;

  localparam int FRACTION_BITS_PRESSURE_DEF    = 6;
  localparam int FRACTION_BITS_TEMPERATURE_DEF = 8;
  localparam int QUEUE_DEPTH_DEF               = 2;

  // fixed point denominators: temperature n/2^48, pressure acc/2^181
  localparam int TEMP_DEN_BITS  = 48;
  localparam int PRESS_DEN_BITS = 181;

  localparam int PRESS_LOW_PA  = 10000;
  localparam int PRESS_HIGH_PA = 130000;
  localparam int PRESSURE_MAX  = 8388607;

  // datapath widths (signed), sized from coefficient ranges
  localparam int N_W  = 60;
  localparam int C3_W = 34;
  localparam int R3_W = 94;
  localparam int R2_W = 154;
  localparam int R1_W = 214;

  // start transfer edge to result transfer edge, in clock edges
  localparam int LATENCY = 23;

  typedef enum logic [1:0] {
    STATUS_IN_RANGE       = 2'd0,
    STATUS_OUT_OF_RANGE   = 2'd1,
    STATUS_NOT_CALIBRATED = 2'd2
  } result_code_t;

  typedef enum logic [1:0] {
    REG_CALIB_LOW  = 2'd0,
    REG_CALIB_MID  = 2'd1,
    REG_CALIB_HIGH = 2'd2,
    REG_CALIB_VLD  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
    logic             calibrated;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } item_slot_t;

endpackage

### rtl/core/barometric_pressure_compensation.sv
// Barometric pressure compensation. Pulse start with a raw pressure and raw
// temperature code while busy is low; that sample is taken on the edge. The
// result (pressure_pa Q17.6 Pa, temperature_c Q8.8 degC, result_status) shows
// on the outputs for exactly one cycle with done high, in order. A new sample
// may be started every cycle while busy is low: the datapath is fully
// pipelined, its depth set by three chained Horner multiply-accumulate units
// built from 32x32 limb products. The receiver cannot stall; busy only rises
// in reset or if the two-entry queue between the input stage and the datapath
// is full. Load the 21 calibration bytes over the cfg channel (cfg_ready is
// always high), then write calibration_valid = 1. The user must change
// configuration only while no sample is in flight; the block itself does not
// enforce this. Without valid calibration the result is zero with status not
// calibrated.
module barometric_pressure_compensation
  import bpc_pkg::*;
#(
  parameter int FRACTION_BITS_PRESSURE    = FRACTION_BITS_PRESSURE_DEF,
  parameter int FRACTION_BITS_TEMPERATURE = FRACTION_BITS_TEMPERATURE_DEF,
  parameter int QUEUE_DEPTH               = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [RAW_W-1:0]         raw_pressure,
  input  logic [RAW_W-1:0]         raw_temperature,
  output logic                     done,
  output logic [PRESSURE_W-1:0]    pressure_pa,
  output logic signed [TEMP_W-1:0] temperature_c,
  output logic [1:0]               result_status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  logic [CFG_DATA_W-1:0] calib_bytes_low;
  logic [CFG_DATA_W-1:0] calib_bytes_mid;
  logic [CFG_HIGH_W-1:0] calib_bytes_high;
  logic                  calibration_valid;

  item_slot_t push;
  item_slot_t head;
  logic       queue_ready;
  logic       pop;

  assign cfg_ready = 1'b1;

  // register file; each transfer replaces one register
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_bytes_low   <= '0;
      calib_bytes_mid   <= '0;
      calib_bytes_high  <= '0;
      calibration_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_CALIB_LOW:  calib_bytes_low   <= cfg_data;
        REG_CALIB_MID:  calib_bytes_mid   <= cfg_data;
        REG_CALIB_HIGH: calib_bytes_high  <= cfg_data[CFG_HIGH_W-1:0];
        REG_CALIB_VLD:  calibration_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input stage: takes the sample and tags it with the calibration state
  bpc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .raw_pressure      (raw_pressure),
    .raw_temperature   (raw_temperature),
    .calibration_valid (calibration_valid),
    .queue_ready       (queue_ready),
    .busy              (busy),
    .push              (push)
  );

  bpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .ready (queue_ready),
    .pop   (pop),
    .head  (head)
  );

  // datapath: 21 stages from queue head to result register
  bpc_back #(
    .FRACTION_BITS_PRESSURE    (FRACTION_BITS_PRESSURE),
    .FRACTION_BITS_TEMPERATURE (FRACTION_BITS_TEMPERATURE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .calib         ({calib_bytes_high, calib_bytes_mid, calib_bytes_low}),
    .head          (head),
    .pop           (pop),
    .done          (done),
    .pressure_pa   (pressure_pa),
    .temperature_c (temperature_c),
    .result_status (result_status)
  );

endmodule

### rtl/core/bpc_front.sv
module bpc_front
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RAW_W-1:0] raw_pressure,
  input  logic [RAW_W-1:0] raw_temperature,
  input  logic             calibration_valid,
  input  logic             queue_ready,
  output logic             busy,
  output item_slot_t       push
);

  item_slot_t slot;
  logic       take;

  assign busy = rst || (slot.valid && !queue_ready);
  assign take = start && !busy;
  assign push = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      if (take) begin
        slot.valid <= 1'b1;
      end else if (queue_ready) begin
        slot.valid <= 1'b0;
      end
    end
    if (take) begin
      slot.item.raw_pressure    <= raw_pressure;
      slot.item.raw_temperature <= raw_temperature;
      // classify: uncalibrated items get a fixed zero result downstream
      slot.item.calibrated      <= calibration_valid;
    end
  end

endmodule

### rtl/core/bpc_queue.sv
module bpc_queue
  import bpc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  item_slot_t push,
  output logic       ready,
  input  logic       pop,
  output item_slot_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_item_t       entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign ready      = count < CNT_W'(DEPTH);
  assign do_push    = push.valid && ready;
  assign do_pop     = pop && (count != '0);
  assign head.valid = count != '0;
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push.item;
    end
  end

endmodule

### rtl/core/bpc_mac.sv
// r = c + a * n, with n given as magnitude and sign; 32x32 limbs
module bpc_mac
  import bpc_pkg::*;
#(
  parameter int WA = C3_W,
  parameter int WR = R3_W
) (
  input  logic                 clk,
  input  logic signed [WA-1:0] a,
  input  logic        [63:0]   n_mag,
  input  logic                 n_neg,
  input  logic signed [WR-1:0] c,
  output logic signed [WR-1:0] r
);

  localparam int LA = (WA + 31) / 32;
  localparam int AW = 32 * LA;
  localparam int PW = AW + 32;
  localparam int MW = AW + 64;

  logic [AW-1:0]        amag1;
  logic [63:0]          nm1;
  logic                 neg1, neg2, neg3, neg4;
  logic signed [WR-1:0] c1, c2, c3, c4;
  logic [63:0]          prod_lo [LA];
  logic [63:0]          prod_hi [LA];
  logic [PW-1:0]        e0, o0, e1, o1;
  logic [PW-1:0]        x3, y3;
  logic [MW-1:0]        m4;
  logic [WR-1:0]        mt;

  always_comb begin
    e0 = '0;
    o0 = '0;
    e1 = '0;
    o1 = '0;
    for (int i = 0; i < LA; i += 2) begin
      e0[32*i +: 64] = prod_lo[i];
      e1[32*i +: 64] = prod_hi[i];
    end
    for (int i = 1; i < LA; i += 2) begin
      o0[32*(i-1) +: 64] = prod_lo[i];
      o1[32*(i-1) +: 64] = prod_hi[i];
    end
  end

  assign mt = WR'(m4);

  always_ff @(posedge clk) begin
    amag1 <= AW'($unsigned(a[WA-1] ? -a : a));
    nm1   <= n_mag;
    neg1  <= a[WA-1] ^ n_neg;
    c1    <= c;

    for (int i = 0; i < LA; i++) begin
      prod_lo[i] <= amag1[32*i +: 32] * nm1[31:0];
      prod_hi[i] <= amag1[32*i +: 32] * nm1[63:32];
    end
    neg2 <= neg1;
    c2   <= c1;

    x3   <= e0 + (o0 << 32);
    y3   <= e1 + (o1 << 32);
    neg3 <= neg2;
    c3   <= c2;

    m4   <= MW'(x3) + (MW'(y3) << 32);
    neg4 <= neg3;
    c4   <= c3;

    r <= neg4 ? c4 - $signed(mt) : c4 + $signed(mt);
  end

endmodule

### rtl/core/bpc_back.sv
module bpc_back
  import bpc_pkg::*;
#(
  parameter int FRACTION_BITS_PRESSURE    = FRACTION_BITS_PRESSURE_DEF,
  parameter int FRACTION_BITS_TEMPERATURE = FRACTION_BITS_TEMPERATURE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CALIB_W-1:0]       calib,
  input  item_slot_t               head,
  output logic                     pop,
  output logic                     done,
  output logic [PRESSURE_W-1:0]    pressure_pa,
  output logic signed [TEMP_W-1:0] temperature_c,
  output logic [1:0]               result_status
);

  localparam int TSH = TEMP_DEN_BITS - FRACTION_BITS_TEMPERATURE;
  localparam int PSH = PRESS_DEN_BITS - FRACTION_BITS_PRESSURE;
  localparam logic signed [R1_W-1:0] LO_BOUND = R1_W'(PRESS_LOW_PA) <<< PRESS_DEN_BITS;
  localparam logic signed [R1_W-1:0] HI_BOUND = R1_W'(PRESS_HIGH_PA) <<< PRESS_DEN_BITS;
  localparam logic signed [R1_W-1:0] P_MAX    = R1_W'(PRESSURE_MAX);
  localparam logic signed [R1_W-1:0] P_HALF   = R1_W'(1) <<< (PSH - 1);

  // trim coefficients, little endian bytes
  logic [15:0]        u0, u2, u11, u13;
  logic signed [7:0]  s4, s9, s10, s15, s16, s19, s20;
  logic signed [15:0] s17;
  logic signed [16:0] a1, a2;

  assign u0  = calib[0 +: 16];
  assign u2  = calib[16 +: 16];
  assign s4  = $signed(calib[32 +: 8]);
  assign a1  = $signed({calib[55], calib[40 +: 16]}) - 17'sd16384;
  assign a2  = $signed({calib[71], calib[56 +: 16]}) - 17'sd16384;
  assign s9  = $signed(calib[72 +: 8]);
  assign s10 = $signed(calib[80 +: 8]);
  assign u11 = calib[88 +: 16];
  assign u13 = calib[104 +: 16];
  assign s15 = $signed(calib[120 +: 8]);
  assign s16 = $signed(calib[128 +: 8]);
  assign s17 = $signed(calib[136 +: 16]);
  assign s19 = $signed(calib[152 +: 8]);
  assign s20 = $signed(calib[160 +: 8]);

  assign pop = head.valid;

  logic                vld_d [20];
  logic                cls_d [20];

  logic signed [24:0]  dt1;
  logic [RAW_W-1:0]    p1, p2, p3;
  logic signed [41:0]  m1_2;
  logic signed [49:0]  sq_2;
  logic signed [C3_W-1:0] c3_2, c3_3, c3_4;
  logic [47:0]         pp2, pp3;
  logic signed [N_W-1:0] n3;
  logic [71:0]         ppp3;

  logic signed [TEMP_W-1:0] tq4;
  logic [63:0]         nmag4;
  logic                nneg4;
  logic signed [R3_W-1:0] c2_4;
  logic signed [41:0]  a2p4, a1p4;
  logic signed [57:0]  s19pp4;
  logic signed [65:0]  s17pp4;
  logic signed [81:0]  s20ppp4;

  logic signed [R2_W-1:0] c1_5;
  logic signed [R1_W-1:0] c0x5, c0y5, c0_6;

  logic signed [R2_W-1:0] c1_d [4];
  logic signed [R1_W-1:0] c0_d [8];
  logic [63:0]            nmag_d [10];
  logic                   nneg_d [10];
  logic signed [TEMP_W-1:0] tq_d [16];

  logic signed [R3_W-1:0] r3;
  logic signed [R2_W-1:0] r2;
  logic signed [R1_W-1:0] acc;
  logic signed [R1_W-1:0] acc20, rnd20, p_shift;
  logic                   lo_ok20;

  logic signed [60:0]     t_round, t_shift;
  logic signed [TEMP_W-1:0] tq_sat;
  logic [N_W-1:0]         n_abs;
  logic [PRESSURE_W-1:0]  p_sat;

  always_comb begin
    t_round = 61'(n3) + (61'sd1 <<< (TSH - 1));
    t_shift = t_round >>> TSH;
    if (t_shift > 61'sd32767) begin
      tq_sat = 16'sh7FFF;
    end else if (t_shift < -61'sd32768) begin
      tq_sat = 16'sh8000;
    end else begin
      tq_sat = t_shift[TEMP_W-1:0];
    end
    n_abs   = $unsigned(n3[N_W-1] ? -n3 : n3);
    p_shift = rnd20 >>> PSH;
    if (p_shift < 0) begin
      p_sat = '0;
    end else if (p_shift > P_MAX) begin
      p_sat = PRESSURE_W'(PRESSURE_MAX);
    end else begin
      p_sat = p_shift[PRESSURE_W-1:0];
    end
  end

  // cubic in n by Horner: ((c3 n + c2) n + c1) n + c0
  bpc_mac #(.WA(C3_W), .WR(R3_W)) u_mac3 (
    .clk(clk), .a(c3_4), .n_mag(nmag4), .n_neg(nneg4), .c(c2_4), .r(r3)
  );
  bpc_mac #(.WA(R3_W), .WR(R2_W)) u_mac2 (
    .clk(clk), .a(r3), .n_mag(nmag_d[4]), .n_neg(nneg_d[4]), .c(c1_d[3]), .r(r2)
  );
  bpc_mac #(.WA(R2_W), .WR(R1_W)) u_mac1 (
    .clk(clk), .a(r2), .n_mag(nmag_d[9]), .n_neg(nneg_d[9]), .c(c0_d[7]), .r(acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 20; k++) vld_d[k] <= 1'b0;
      done <= 1'b0;
    end else begin
      vld_d[0] <= head.valid;
      for (int k = 1; k < 20; k++) vld_d[k] <= vld_d[k-1];
      done <= vld_d[19];
    end

    cls_d[0] <= head.item.calibrated;
    for (int k = 1; k < 20; k++) cls_d[k] <= cls_d[k-1];

    // stage 1
    dt1 <= $signed({1'b0, head.item.raw_temperature}) - $signed({1'b0, u0, 8'd0});
    p1  <= head.item.raw_pressure;

    // stage 2
    m1_2 <= dt1 * $signed({1'b0, u2});
    sq_2 <= dt1 * dt1;
    c3_2 <= (C3_W'(s16) <<< 22) + s10 * $signed({1'b0, p1});
    pp2  <= p1 * p1;
    p2   <= p1;

    // stage 3
    n3   <= (N_W'(m1_2) <<< 18) + sq_2 * N_W'(s4);
    ppp3 <= pp2 * p2;
    pp3  <= pp2;
    p3   <= p2;
    c3_3 <= c3_2;

    // stage 4
    tq4     <= tq_sat;
    nmag4   <= 64'(n_abs);
    nneg4   <= n3[N_W-1];
    c3_4    <= c3_3;
    c2_4    <= (R3_W'(s15) <<< 77) + ((R3_W'(s9) * R3_W'($signed({1'b0, p3}))) <<< 53);
    a2p4    <= a2 * $signed({1'b0, p3});
    a1p4    <= a1 * $signed({1'b0, p3});
    s19pp4  <= s19 * $signed({1'b0, pp3});
    s17pp4  <= s17 * $signed({1'b0, pp3});
    s20ppp4 <= s20 * $signed({1'b0, ppp3});

    // stage 5, 6: remaining coefficients
    c1_5 <= (R2_W'($signed({1'b0, u13})) <<< 127) + (R2_W'(a2p4) <<< 104)
          + (R2_W'(s19pp4) <<< 85);
    c0x5 <= (R1_W'($signed({1'b0, u11})) <<< 184) + (R1_W'(a1p4) <<< 161);
    c0y5 <= (R1_W'(s17pp4) <<< 133) + (R1_W'(s20ppp4) <<< 116);
    c0_6 <= c0x5 + c0y5;

    c1_d[0] <= c1_5;
    for (int k = 1; k < 4; k++) c1_d[k] <= c1_d[k-1];
    c0_d[0] <= c0_6;
    for (int k = 1; k < 8; k++) c0_d[k] <= c0_d[k-1];
    nmag_d[0] <= nmag4;
    nneg_d[0] <= nneg4;
    for (int k = 1; k < 10; k++) begin
      nmag_d[k] <= nmag_d[k-1];
      nneg_d[k] <= nneg_d[k-1];
    end
    tq_d[0] <= tq4;
    for (int k = 1; k < 16; k++) tq_d[k] <= tq_d[k-1];

    // finish 1: rounding add, lower range bound
    acc20   <= acc;
    rnd20   <= acc + P_HALF;
    lo_ok20 <= acc > LO_BOUND;

    // finish 2: saturate, upper bound, result register
    if (!cls_d[19]) begin
      pressure_pa   <= '0;
      temperature_c <= '0;
      result_status <= STATUS_NOT_CALIBRATED;
    end else begin
      pressure_pa   <= p_sat;
      temperature_c <= tq_d[15];
      result_status <= (lo_ok20 && (acc20 < HI_BOUND)) ? STATUS_IN_RANGE
                                                        : STATUS_OUT_OF_RANGE;
    end
  end

endmodule

### rtl/core/bpc_checker.sv
module bpc_assertions
  import bpc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic [PRESSURE_W-1:0]    pressure_pa,
  input logic signed [TEMP_W-1:0] temperature_c,
  input logic [1:0]               result_status
);

  // every result traces back to exactly one start transfer
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching start transfer");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("start transfer produced no result");

  a_uncal_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result_status == STATUS_NOT_CALIBRATED) |->
      (pressure_pa == '0 && temperature_c == '0))
    else $error("uncalibrated result carries nonzero values");

endmodule

bind barometric_pressure_compensation bpc_assertions u_bpc_assertions (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .pressure_pa   (pressure_pa),
  .temperature_c (temperature_c),
  .result_status (result_status)
);
